@@ rtl/ocu_pkg.sv @@
// Orbit camera update: shared types, register indexes, CORDIC constants and
// rounding helpers. No dependencies; imported by every module of the block.
`default_nettype none

package ocu_pkg;

  // Datapath widths
  localparam int XY_W       = 34;  // CORDIC x/y, signed Q2.30 with headroom
  localparam int Z_W        = 32;  // CORDIC residual angle, 2^32 per turn
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int TRIG_W     = 17;  // Q1.15 after quadrant fold, holds +32768
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOLLY_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MAX   = 3'd7;

  // Quadrant codes taken from the top two angle bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // CORDIC gain compensation, 0.60725293 in Q2.30
  localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

  // Arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [Z_W-1:0] atan_lut(input logic [4:0] idx);
    logic [Z_W-1:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up by a floor shift, then saturate to 16-bit signed
  function automatic logic signed [15:0] rnd_sat16(input logic signed [PROD_W-1:0] v,
                                                   input int unsigned sh);
    logic signed [PROD_W-1:0] r;
    r = v + $signed(PROD_W'(1) << (sh - 1));
    r = r >>> sh;
    if (r > SAT_HI) begin
      return 16'sh7fff;
    end else if (r < SAT_LO) begin
      return -16'sh8000;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/orbit_camera_update_unit.sv @@
// Orbit camera update: one item in, one eye point result out.
// An item runs from accept through two passes of the shared CORDIC unit (pitch,
// then yaw) and the multiply states to FIN, which loads the output register.
// A new item is taken only once the last has left FIN for idle; a result still
// waiting holds the next in FIN.
// Reset (async, active low): config registers and camera state to defaults.
`default_nettype none

module orbit_camera_update_unit import ocu_pkg::*; #(
  parameter int ANGLE_BITS   = 20,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [7:0]     stick_x_i,
  input  logic signed [7:0]     stick_y_i,
  input  logic                  dolly_in_i,
  input  logic                  dolly_out_i,
  // Result item channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    eye_x_o,
  output logic signed [15:0]    eye_y_o,
  output logic signed [15:0]    eye_z_o,
  output logic [19:0]           yaw_out_o,
  output logic [17:0]           pitch_out_o,
  output logic [14:0]           dist_out_o
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;   // wait for an item
  localparam logic [3:0] ST_YAW    = 4'd1;   // multiply stick x by yaw gain
  localparam logic [3:0] ST_PITCH  = 4'd2;   // update yaw and distance, multiply pitch
  localparam logic [3:0] ST_PCLAMP = 4'd3;   // update and clamp pitch
  localparam logic [3:0] ST_CSP    = 4'd4;   // launch CORDIC on pitch
  localparam logic [3:0] ST_WAITP  = 4'd5;
  localparam logic [3:0] ST_CSY    = 4'd6;   // launch CORDIC on yaw
  localparam logic [3:0] ST_WAITY  = 4'd7;
  localparam logic [3:0] ST_MSP    = 4'd8;   // d * sin(p)
  localparam logic [3:0] ST_MCP    = 4'd9;   // d * cos(p), round eye y
  localparam logic [3:0] ST_MX     = 4'd10;  // dcp * sin(y)
  localparam logic [3:0] ST_MZ     = 4'd11;  // dcp * cos(y), round eye x
  localparam logic [3:0] ST_FIN    = 4'd12;  // round eye z, load output register

  localparam int YAW_RESET = 100138;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, decoded by index
  // ---------------------------------------------------------------------------
  logic [6:0]  dead_zone_q;
  logic [11:0] yaw_gain_q, pitch_gain_q, dolly_step_q;
  logic [17:0] pitch_min_q, pitch_max_q;
  logic [14:0] dist_min_q, dist_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q  <= 7'd8;
      yaw_gain_q   <= 12'd250;
      pitch_gain_q <= 12'd200;
      pitch_min_q  <= 18'd8344;
      pitch_max_q  <= 18'd233634;
      dolly_step_q <= 12'd90;
      dist_min_q   <= 15'd3840;
      dist_max_q   <= 15'd23040;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data_i[6:0];
        CFG_YAW_GAIN:   yaw_gain_q   <= cfg_data_i[11:0];
        CFG_PITCH_GAIN: pitch_gain_q <= cfg_data_i[11:0];
        CFG_PITCH_MIN:  pitch_min_q  <= cfg_data_i[17:0];
        CFG_PITCH_MAX:  pitch_max_q  <= cfg_data_i[17:0];
        CFG_DOLLY_STEP: dolly_step_q <= cfg_data_i[11:0];
        CFG_DIST_MIN:   dist_min_q   <= cfg_data_i[14:0];
        CFG_DIST_MAX:   dist_max_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture and dead zone
  // ---------------------------------------------------------------------------
  logic [3:0]        state_q, state_d;
  logic signed [7:0] stick_x_q, stick_y_q, sx, sy;
  logic              dolly_in_q, dolly_out_q;
  logic [7:0]        mag_x, mag_y;
  logic              in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stick_x_q   <= stick_x_i;
      stick_y_q   <= stick_y_i;
      dolly_in_q  <= dolly_in_i;
      dolly_out_q <= dolly_out_i;
    end
  end

  // Magnitude is unsigned so that -128 reads as 128
  assign mag_x = stick_x_q[7] ? 8'(-stick_x_q) : stick_x_q;
  assign mag_y = stick_y_q[7] ? 8'(-stick_y_q) : stick_y_q;
  assign sx    = (mag_x < {1'b0, dead_zone_q}) ? '0 : stick_x_q;
  assign sy    = (mag_y < {1'b0, dead_zone_q}) ? '0 : stick_y_q;

  // ---------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // ---------------------------------------------------------------------------
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_A_W-1:0] dcp_q;
  logic [14:0]               dist_q;
  logic signed [TRIG_W-1:0]  sp_q, cp_q, syt_q, cyt_q;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_YAW: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-8){sx[7]}}, sx});
        mul_b  = $signed({5'b0, yaw_gain_q});
      end
      ST_PITCH: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-8){sy[7]}}, sy});
        mul_b  = $signed({5'b0, pitch_gain_q});
      end
      ST_MSP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-15){1'b0}}, dist_q});
        mul_b  = sp_q;
      end
      ST_MCP: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_A_W-15){1'b0}}, dist_q});
        mul_b  = cp_q;
      end
      ST_MX: begin
        // d*cos(p) is taken straight from the product register
        mul_en = 1'b1;
        mul_a  = prod[MUL_A_W-1:0];
        mul_b  = syt_q;
      end
      ST_MZ: begin
        mul_en = 1'b1;
        mul_a  = dcp_q;
        mul_b  = cyt_q;
      end
      default: ;
    endcase
  end

  ocu_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // Shared CORDIC: pitch first, then yaw
  // ---------------------------------------------------------------------------
  logic                     cord_start, cord_done;
  logic [ANGLE_BITS-1:0]    cord_angle;
  logic signed [TRIG_W-1:0] cord_sin, cord_cos;
  logic [ANGLE_BITS-1:0]    yaw_q;
  logic [17:0]              pitch_q;

  assign cord_start = (state_q == ST_CSP) || (state_q == ST_CSY);
  // Pitch is taken modulo the angle range
  assign cord_angle = (state_q == ST_CSY) ? yaw_q : ANGLE_BITS'(pitch_q);

  ocu_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .angle_i (cord_angle),
    .done_o  (cord_done),
    .sin_o   (cord_sin),
    .cos_o   (cord_cos)
  );

  // ---------------------------------------------------------------------------
  // Camera state update
  // ---------------------------------------------------------------------------
  logic signed [20:0] p_sum, p_clamp;
  logic signed [16:0] d_sum, d_clamp;

  // Pitch: minimum clamp first, maximum second so max wins on crossed limits
  always_comb begin
    p_sum   = $signed({3'b0, pitch_q}) + $signed(prod[20:0]);
    p_clamp = p_sum;
    if (p_clamp < $signed({3'b0, pitch_min_q})) begin
      p_clamp = $signed({3'b0, pitch_min_q});
    end
    if (p_clamp > $signed({3'b0, pitch_max_q})) begin
      p_clamp = $signed({3'b0, pitch_max_q});
    end
  end

  // Distance: both buttons cancel, then the same clamp order
  always_comb begin
    d_sum = $signed({2'b0, dist_q});
    if (dolly_in_q) begin
      d_sum = d_sum - $signed({5'b0, dolly_step_q});
    end
    if (dolly_out_q) begin
      d_sum = d_sum + $signed({5'b0, dolly_step_q});
    end
    d_clamp = d_sum;
    if (d_clamp < $signed({2'b0, dist_min_q})) begin
      d_clamp = $signed({2'b0, dist_min_q});
    end
    if (d_clamp > $signed({2'b0, dist_max_q})) begin
      d_clamp = $signed({2'b0, dist_max_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= ANGLE_BITS'(YAW_RESET);
      pitch_q <= 18'd66759;
      dist_q  <= 15'd11520;
    end else begin
      if (state_q == ST_PITCH) begin
        // Yaw wraps by dropping the carry out of the angle width
        yaw_q  <= yaw_q + prod[ANGLE_BITS-1:0];
        dist_q <= d_clamp[14:0];
      end
      if (state_q == ST_PCLAMP) begin
        pitch_q <= p_clamp[17:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Trig capture and eye staging
  // ---------------------------------------------------------------------------
  logic signed [15:0] eye_x_q, eye_y_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAITP && cord_done) begin
      sp_q <= cord_sin;
      cp_q <= cord_cos;
    end
    if (state_q == ST_WAITY && cord_done) begin
      syt_q <= cord_sin;
      cyt_q <= cord_cos;
    end
    if (state_q == ST_MCP) begin
      eye_y_q <= rnd_sat16(prod, 15);
    end
    if (state_q == ST_MX) begin
      dcp_q <= prod[MUL_A_W-1:0];
    end
    if (state_q == ST_MZ) begin
      eye_x_q <= rnd_sat16(prod, 30);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished result while the next item runs
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic               out_load;
  logic signed [15:0] eye_x_out_q, eye_y_out_q, eye_z_out_q;
  logic [19:0]        yaw_out_q;
  logic [17:0]        pitch_out_q;
  logic [14:0]        dist_out_q;

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      eye_x_out_q <= eye_x_q;
      eye_y_out_q <= eye_y_q;
      eye_z_out_q <= rnd_sat16(prod, 30);
      yaw_out_q   <= 20'(yaw_q);
      pitch_out_q <= pitch_q;
      dist_out_q  <= dist_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign eye_x_o     = eye_x_out_q;
  assign eye_y_o     = eye_y_out_q;
  assign eye_z_o     = eye_z_out_q;
  assign yaw_out_o   = yaw_out_q;
  assign pitch_out_o = pitch_out_q;
  assign dist_out_o  = dist_out_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_YAW;
      ST_YAW:    state_d = ST_PITCH;
      ST_PITCH:  state_d = ST_PCLAMP;
      ST_PCLAMP: state_d = ST_CSP;
      ST_CSP:    state_d = ST_WAITP;
      ST_WAITP:  if (cord_done) state_d = ST_CSY;
      ST_CSY:    state_d = ST_WAITY;
      ST_WAITY:  if (cord_done) state_d = ST_MSP;
      ST_MSP:    state_d = ST_MCP;
      ST_MCP:    state_d = ST_MX;
      ST_MX:     state_d = ST_MZ;
      ST_MZ:     state_d = ST_FIN;
      ST_FIN:    if (out_load) state_d = ST_IDLE;  // hold until the slot frees
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_YAW)
    else $error("accepted item did not start the sequence");

  a_cordic_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == ST_WAITP || state_q == ST_WAITY))
    else $error("CORDIC finished outside a wait state");

  a_fin_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && state_q == ST_IDLE)
    else $error("finished item was not placed in the output register");

endmodule

`default_nettype wire

@@ rtl/ocu_mult.sv @@
// Shared signed multiplier with registered product for the orbit camera update.
// Depends on ocu_pkg for operand and product widths.
`default_nettype none

module ocu_mult import ocu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic                     vld_q;

  // Track whether the product register has ever been loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= 1'b1;
    end
  end

  // Hold the product between uses
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = vld_q ? prod_q : '0;

endmodule

`default_nettype wire

@@ rtl/ocu_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a registered
// rounding and quadrant-fold step. Depends on ocu_pkg (tables, rounding).
`default_nettype none

module ocu_cordic import ocu_pkg::*; #(
  parameter int ANGLE_BITS   = 20,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ANGLE_BITS-1:0]    angle_i,
  output logic                     done_o,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam int PAD_W = Z_W - ANGLE_BITS;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

  logic                     busy_q, fin_q, done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [1:0]               quad_q;
  logic signed [XY_W-1:0]   x_q, y_q, x_sh, y_sh;
  logic signed [Z_W-1:0]    z_q, atan_s, z_init;
  logic signed [15:0]       s16, c16;
  logic signed [TRIG_W-1:0] s17, c17, sin_q, cos_q;
  logic                     last;

  assign last   = (cnt_q == LAST_STEP);
  assign x_sh   = x_q >>> cnt_q;
  assign y_sh   = y_q >>> cnt_q;
  assign atan_s = $signed(atan_lut(5'(cnt_q)));
  assign z_init = $signed({2'b00, angle_i[ANGLE_BITS-3:0], {PAD_W{1'b0}}});

  assign s16 = rnd_sat16($signed({{(PROD_W-XY_W){y_q[XY_W-1]}}, y_q}), 15);
  assign c16 = rnd_sat16($signed({{(PROD_W-XY_W){x_q[XY_W-1]}}, x_q}), 15);
  assign s17 = $signed({s16[15], s16});
  assign c17 = $signed({c16[15], c16});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= busy_q && last;
      done_q <= fin_q;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_K;
      y_q    <= '0;
      z_q    <= z_init;
      quad_q <= angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
    end else if (busy_q) begin
      // Rotate toward zero residual angle
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_s;
      end
    end
    if (fin_q) begin
      case (quad_q)
        QUAD_0: begin sin_q <= s17;  cos_q <= c17;  end
        QUAD_1: begin sin_q <= c17;  cos_q <= -s17; end
        QUAD_2: begin sin_q <= -s17; cos_q <= -c17; end
        default: begin sin_q <= -c17; cos_q <= s17; end
      endcase
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for orbit_camera_update_unit: a directed table of frames
// and register writes, then random frames under eight register settings.
// Depends on ocu_pkg for the register indexes, quadrant codes and the CORDIC gain.
module tb_top;
  import ocu_pkg::*;

  localparam int ANGLE_W      = 20;
  localparam int ROT_STEPS    = 16;
  localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake on any channel
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;    // above the accept-to-result latency
  localparam int PLAN_ROWS    = 24;

  // Arctangent of 2^-i, 2^32 units per turn
  localparam logic [31:0] ATAN_TURN [ROT_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic              din;
    logic              dout;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] ez;
    logic [19:0]        yaw;
    logic [17:0]        pitch;
    logic [14:0]        dist_val;
  } eye_result_t;

  typedef struct packed {
    logic [6:0]  dead_zone;
    logic [11:0] yaw_gain;
    logic [11:0] pitch_gain;
    logic [17:0] pitch_min;
    logic [17:0] pitch_max;
    logic [11:0] dolly_step;
    logic [14:0] dist_min;
    logic [14:0] dist_max;
  } cam_cfg_t;

  localparam cam_cfg_t CFG_AT_RESET = '{7'd8, 12'd250, 12'd200, 18'd8344, 18'd233634,
                                        12'd90, 15'd3840, 15'd23040};

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

  // One directed step: a frame, or a register write. Where typed is set, the
  // camera state fields of the result are checked against the typed values.
  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    int                    sx;
    int                    sy;
    bit                    din;
    bit                    dout;
    bit                    typed;
    int                    yaw;
    int                    pitch;
    int                    dist_val;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic signed [7:0] stick_x   = '0;
  logic signed [7:0] stick_y   = '0;
  logic              dolly_in  = 1'b0;
  logic              dolly_out = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] eye_x, eye_y, eye_z;
  logic [19:0]        yaw_out;
  logic [17:0]        pitch_out;
  logic [14:0]        dist_out;

  // Predictor copy of the registers and the camera state
  cam_cfg_t          shadow_cfg;
  logic [ANGLE_W-1:0] yaw_q;
  logic [17:0]       pitch_q;
  logic [14:0]       dist_q;

  eye_result_t eye_pending[$];
  plan_row_t   plan [PLAN_ROWS];

  int unsigned fault_count   = 0;
  int          results_taken = 0;
  int          quiet_cycles  = 0;
  int          burst_left    = 0;

  // Receiver pattern state
  int          hold_left    = 0;
  int          next_hold_at = 150;
  int          pat_age      = 0;
  logic [15:0] stall_pat    = '1;
  logic [3:0]  pat_pos      = '0;

  orbit_camera_update_unit #(
    .ANGLE_BITS  (ANGLE_W),
    .CORDIC_STEPS(ROT_STEPS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .stick_x_i  (stick_x),
    .stick_y_i  (stick_y),
    .dolly_in_i (dolly_in),
    .dolly_out_i(dolly_out),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .eye_x_o    (eye_x),
    .eye_y_o    (eye_y),
    .eye_z_o    (eye_z),
    .yaw_out_o  (yaw_out),
    .pitch_out_o(pitch_out),
    .dist_out_o (dist_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Add half an LSB, floor shift, then clamp to 16-bit signed
  function automatic longint round_half_up_sat(input longint v, input int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  // Fold the quadrant off the top two bits, rotate the rest, then unfold
  function automatic void cordic_sin_cos(input logic [ANGLE_W-1:0] ang,
                                         output longint s_q15, output longint c_q15);
    logic [31:0] turn;
    longint x, y, z, dx, dy, s, c;
    turn = {ang, {(32 - ANGLE_W){1'b0}}};
    x = longint'(CORDIC_K);
    y = 0;
    z = longint'({2'b00, turn[29:0]});
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURN[i]);
      end
    end
    s = round_half_up_sat(y, 15);
    c = round_half_up_sat(x, 15);
    case (turn[31:30])
      QUAD_0: begin s_q15 = s;  c_q15 = c;  end
      QUAD_1: begin s_q15 = c;  c_q15 = -s; end
      QUAD_2: begin s_q15 = -s; c_q15 = -c; end
      default: begin s_q15 = -c; c_q15 = s; end
    endcase
  endfunction

  function automatic longint gated_axis(input logic signed [7:0] raw, input logic [6:0] dz);
    longint v, m;
    v = longint'(raw);
    m = (v < 0) ? -v : v;
    return (m < longint'(dz)) ? 0 : v;
  endfunction

  // Step the camera by one frame and return the eye point it gives
  function automatic eye_result_t advance_camera(input frame_t f);
    longint sx, sy, p, d, sp, cp, syt, cyt, dcp;
    eye_result_t r;
    sx = gated_axis(f.sx, shadow_cfg.dead_zone);
    sy = gated_axis(f.sy, shadow_cfg.dead_zone);
    yaw_q = ANGLE_W'(longint'(yaw_q) + sx * longint'(shadow_cfg.yaw_gain));
    p = longint'(pitch_q) + sy * longint'(shadow_cfg.pitch_gain);
    if (p < longint'(shadow_cfg.pitch_min)) p = longint'(shadow_cfg.pitch_min);
    if (p > longint'(shadow_cfg.pitch_max)) p = longint'(shadow_cfg.pitch_max);
    pitch_q = 18'(p);
    d = longint'(dist_q);
    if (f.din) d -= longint'(shadow_cfg.dolly_step);
    if (f.dout) d += longint'(shadow_cfg.dolly_step);
    if (d < longint'(shadow_cfg.dist_min)) d = longint'(shadow_cfg.dist_min);
    if (d > longint'(shadow_cfg.dist_max)) d = longint'(shadow_cfg.dist_max);
    dist_q = 15'(d);
    cordic_sin_cos(ANGLE_W'(pitch_q), sp, cp);
    cordic_sin_cos(yaw_q, syt, cyt);
    dcp = d * cp;
    r.ex       = 16'(round_half_up_sat(dcp * syt, 30));
    r.ey       = 16'(round_half_up_sat(d * sp, 15));
    r.ez       = 16'(round_half_up_sat(dcp * cyt, 30));
    r.yaw      = yaw_q;
    r.pitch    = pitch_q;
    r.dist_val = dist_q;
    return r;
  endfunction

  // Mostly values around the dead zone edge and the extremes
  function automatic logic signed [7:0] pick_stick(input logic [6:0] dz);
    int v;
    case ($urandom_range(0, 9))
      0: v = -128;
      1: v = 127;
      2: v = -127;
      3, 4: v = int'(dz) - 1 + int'($urandom_range(0, 2));
      5: v = -(int'(dz) - 1 + int'($urandom_range(0, 2)));
      default: v = int'($urandom_range(0, 255)) - 128;
    endcase
    return 8'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one frame, hold it until accepted, queue its expected result. Keep
  // valid high into the next frame while the burst lasts, else drop it for a gap.
  task automatic send_frame(input frame_t f, input bit stay, input bit typed,
                            input eye_result_t typed_val);
    eye_result_t want;
    int gap;
    in_valid  <= 1'b1;
    stick_x   <= f.sx;
    stick_y   <= f.sy;
    dolly_in  <= f.din;
    dolly_out <= f.dout;
    do @(posedge clk); while (!in_ready);
    want = advance_camera(f);
    if (typed) begin
      want.yaw      = typed_val.yaw;
      want.pitch    = typed_val.pitch;
      want.dist_val = typed_val.dist_val;
    end
    eye_pending.push_back(want);
    if (!stay || burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      if (!stay) gap = 1;
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Wait until every queued result has come back
  task automatic settle_block();
    while (eye_pending.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle; the predictor copy keeps only
  // the low bits that the register holds.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    cfg_index <= idx;
    cfg_data  <= word;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEAD_ZONE:  shadow_cfg.dead_zone  = word[6:0];
      CFG_YAW_GAIN:   shadow_cfg.yaw_gain   = word[11:0];
      CFG_PITCH_GAIN: shadow_cfg.pitch_gain = word[11:0];
      CFG_PITCH_MIN:  shadow_cfg.pitch_min  = word[17:0];
      CFG_PITCH_MAX:  shadow_cfg.pitch_max  = word[17:0];
      CFG_DOLLY_STEP: shadow_cfg.dolly_step = word[11:0];
      CFG_DIST_MIN:   shadow_cfg.dist_min   = word[14:0];
      default:        shadow_cfg.dist_max   = word[14:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall on a rotating pattern, with long hold-offs now and then
  // so that the block fills up and drops in_ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (results_taken >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 500;
      out_ready    <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat <= '1;
          1: stall_pat <= 16'($urandom);
          2: stall_pat <= 16'($urandom & $urandom);
          default: stall_pat <= 16'($urandom | $urandom);
        endcase
        pat_age <= $urandom_range(20, 120);
      end else begin
        pat_age <= pat_age - 1;
      end
      out_ready <= stall_pat[pat_pos];
      pat_pos   <= pat_pos + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    eye_result_t want, got;
    if (out_valid && out_ready) begin
      results_taken <= results_taken + 1;
      got.ex       = eye_x;
      got.ey       = eye_y;
      got.ez       = eye_z;
      got.yaw      = yaw_out;
      got.pitch    = pitch_out;
      got.dist_val = dist_out;
      if (eye_pending.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result item: x %0d y %0d z %0d yaw %0d pitch %0d dist %0d",
                   got.ex, got.ey, got.ez, got.yaw, got.pitch, got.dist_val);
      end else begin
        want = eye_pending.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display({"mismatch (expected/actual): x %0d/%0d y %0d/%0d z %0d/%0d",
                      " yaw %0d/%0d pitch %0d/%0d dist %0d/%0d"},
                     want.ex, got.ex, want.ey, got.ey, want.ez, got.ez,
                     want.yaw, got.yaw, want.pitch, got.pitch,
                     want.dist_val, got.dist_val);
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cam_cfg_t    c;
    frame_t      f;
    eye_result_t typed_val;
    int          n;
    bit          stay;

    // Directed table. Camera state after each frame is typed in; eye points
    // come from the predictor.
    plan = '{
      // reset state, stick still
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 0, 1, 100138, 66759,  11520},
      // just inside the dead zone on both axes
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    7,    -7,   0, 0, 1, 100138, 66759,  11520},
      // exactly on the dead zone edge
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    8,    -8,   0, 0, 1, 102138, 65159,  11520},
      // both buttons cancel
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    1, 1, 1, 102138, 65159,  11520},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    1, 0, 1, 102138, 65159,  11430},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 1, 1, 102138, 65159,  11520},
      // stick extremes
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    127,  127,  0, 0, 1, 133888, 90559,  11520},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    -128, -128, 0, 0, 1, 101888, 64959,  11520},
      // full pitch gain drives pitch into both clamps
      '{ROW_WRITE, CFG_PITCH_GAIN, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    127,  0, 0, 1, 101888, 233634, 11520},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    -128, 0, 0, 1, 101888, 8344,   11520},
      // full dolly step walks distance up to its upper clamp and back
      '{ROW_WRITE, CFG_DOLLY_STEP, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 1, 1, 101888, 8344,   15615},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 1, 1, 101888, 8344,   19710},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 1, 1, 101888, 8344,   23040},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    1, 0, 1, 101888, 8344,   18945},
      // crossed distance limits: the maximum wins
      '{ROW_WRITE, CFG_DIST_MIN, 32767, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    0,    0,    0, 0, 1, 101888, 8344,   23040},
      // zero dead zone passes a single stick unit
      '{ROW_WRITE, CFG_DEAD_ZONE, 0,     0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    1,    -1,   0, 0, 1, 102138, 8344,   23040},
      // full yaw gain wraps yaw below zero
      '{ROW_WRITE, CFG_YAW_GAIN, 4095,  0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    -128, 0,    0, 0, 1, 626554, 8344,   23040},
      // widest dead zone: 127 passes, 126 does not
      '{ROW_WRITE, CFG_DEAD_ZONE, 127,   0, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_FRAME, CFG_DEAD_ZONE, 0,    -127, 126,  1, 1, 1, 106489, 8344,   23040}
    };

    // Predictor starts from the reset state of the block
    shadow_cfg = CFG_AT_RESET;
    yaw_q      = ANGLE_W'(100138);
    pitch_q    = 18'd66759;
    dist_q     = 15'd11520;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; drain before every register write
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        settle_block();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        f.sx  = 8'(plan[r].sx);
        f.sy  = 8'(plan[r].sy);
        f.din  = plan[r].din;
        f.dout = plan[r].dout;
        typed_val          = '0;
        typed_val.yaw      = 20'(plan[r].yaw);
        typed_val.pitch    = 18'(plan[r].pitch);
        typed_val.dist_val = 15'(plan[r].dist_val);
        stay = (r + 1 < PLAN_ROWS) && (plan[(r + 1) % PLAN_ROWS].kind == ROW_FRAME);
        send_frame(f, stay, plan[r].typed, typed_val);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: c = CFG_AT_RESET;
        1: c = '0;
        2: c = '1;
        3: begin
          c.dead_zone  = $urandom_range(0, 24);
          c.yaw_gain   = $urandom_range(0, 4095);
          c.pitch_gain = $urandom_range(0, 1500);
          c.pitch_min  = $urandom_range(0, 60000);
          c.pitch_max  = $urandom_range(262143, c.pitch_min);
          c.dolly_step = $urandom_range(0, 1200);
          c.dist_min   = $urandom_range(0, 8000);
          c.dist_max   = $urandom_range(32767, c.dist_min);
        end
        4: begin
          c.dead_zone  = $urandom_range(60, 127);
          c.yaw_gain   = $urandom_range(0, 4095);
          c.pitch_gain = $urandom_range(0, 4095);
          c.pitch_min  = $urandom_range(0, 100000);
          c.pitch_max  = $urandom_range(262143, c.pitch_min);
          c.dolly_step = $urandom_range(0, 300);
          c.dist_min   = $urandom_range(0, 16000);
          c.dist_max   = $urandom_range(32767, c.dist_min);
        end
        5: begin
          // crossed limits on both clamps
          c.dead_zone  = $urandom_range(0, 16);
          c.yaw_gain   = $urandom_range(0, 4095);
          c.pitch_gain = $urandom_range(0, 4095);
          c.pitch_min  = $urandom_range(131072, 262143);
          c.pitch_max  = $urandom_range(0, 131071);
          c.dolly_step = $urandom_range(0, 4095);
          c.dist_min   = $urandom_range(16384, 32767);
          c.dist_max   = $urandom_range(0, 16383);
        end
        6: begin
          c.dead_zone  = '0;
          c.yaw_gain   = 12'd4095;
          c.pitch_gain = $urandom_range(1000, 4095);
          c.pitch_min  = '0;
          c.pitch_max  = 18'd262143;
          c.dolly_step = $urandom_range(1000, 4095);
          c.dist_min   = '0;
          c.dist_max   = 15'd32767;
        end
        default: begin
          c.dead_zone  = $urandom_range(0, 12);
          c.yaw_gain   = $urandom_range(1, 40);
          c.pitch_gain = $urandom_range(1, 40);
          c.pitch_min  = $urandom_range(40000, 70000);
          c.pitch_max  = $urandom_range(71000, 100000);
          c.dolly_step = $urandom_range(1, 200);
          c.dist_min   = $urandom_range(2000, 6000);
          c.dist_max   = $urandom_range(6500, 12000);
        end
      endcase

      // Rewrite every register; fill the unused upper data bits with noise
      settle_block();
      write_reg(CFG_DEAD_ZONE,  {11'($urandom), c.dead_zone});
      write_reg(CFG_YAW_GAIN,   {6'($urandom), c.yaw_gain});
      write_reg(CFG_PITCH_GAIN, {6'($urandom), c.pitch_gain});
      write_reg(CFG_PITCH_MIN,  c.pitch_min);
      write_reg(CFG_PITCH_MAX,  c.pitch_max);
      write_reg(CFG_DOLLY_STEP, {6'($urandom), c.dolly_step});
      write_reg(CFG_DIST_MIN,   {3'($urandom), c.dist_min});
      write_reg(CFG_DIST_MAX,   {3'($urandom), c.dist_max});

      n = (p == 1 || p == 2) ? 40 : ((p == 0) ? 250 : 200);
      for (int k = 0; k < n; k++) begin
        f.sx   = pick_stick(shadow_cfg.dead_zone);
        f.sy   = pick_stick(shadow_cfg.dead_zone);
        f.din  = $urandom_range(0, 1);
        f.dout = $urandom_range(0, 1);
        send_frame(f, k != n - 1, 1'b0, '0);
      end
    end

    // Drain, then wait past the block's latency to catch any stray result
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && eye_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
